// File: rtl/core/gmnq_pkg.sv
// Shared types and constants of the grid map neighbor query block.
// Holds field widths, stream bit positions, action codes and register indexes.
// No dependencies.
package gmnq_pkg;

    localparam int CELL_W = 12;   // linear cell index
    localparam int DIM_W  = 13;   // row and column count registers
    localparam int CALC_W = 14;   // candidate cells and rectangle scan addresses
    localparam int PROD_W = 26;   // rows times cols before clamping
    localparam int DEG_W  = 4;
    localparam int CNT_W  = 4;    // divider step counter
    localparam int NUM_DIR = 5;   // wait, north, east, south, west

    localparam int DIR_WAIT  = 0;
    localparam int DIR_NORTH = 1;
    localparam int DIR_EAST  = 2;
    localparam int DIR_SOUTH = 3;
    localparam int DIR_WEST  = 4;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;

    localparam int S_CELL_LSB    = 0;
    localparam int S_BLOCKED_BIT = 12;
    localparam int S_END_LSB     = 13;

    localparam int M_NEXT_LSB  = 0;
    localparam int M_FOUND_BIT = 12;
    localparam int M_DEG_LSB   = 13;
    localparam int M_RFREE_BIT = 17;
    localparam int M_PAD_W     = M_TDATA_W - M_RFREE_BIT - 1;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    localparam logic signed [DEG_W-1:0] DEG_NONE = -4'sd1;
    localparam logic [DEG_W-1:0]        DEG_MAX  = 4'd4;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_MOVES  = 2'd1,
        ACT_DEGREE = 2'd2,
        ACT_RECT   = 2'd3
    } action_t;

endpackage

// File: rtl/core/grid_map_neighbor_query_core.sv
// Top level of the grid map neighbor query block: obstacle bit memory, a
// shared bit-serial divider and the sequencer for writes, move lists, degrees
// and rectangle checks. Depends on gmnq_pkg.
//
// Channel   Direction  Handshake                  Payload
// s_axis    in         s_axis_tvalid/tready       tuser: action; tdata: cell, bit, end cell
// m_axis    out        m_axis_tvalid/tready       tdata: move, found, degree, free; tlast
// apb       in         psel/penable/pready        grid_rows at 0x0, grid_cols at 0x4
//
// One item is worked on at a time. A move list or a degree runs one divider pass and
// reads the five candidate cells; a move list then gives 1 to 5 results, one per cycle
// unless stalled, and a degree gives one. A rectangle check runs two divider passes and
// a multiply, then scans one cell per cycle, stopping early at a blocked cell. After
// reset a clearing pass zeroes the map and holds off input; a stalled result holds the
// output register and the sequencer.
module grid_map_neighbor_query_core #(
    parameter int MAX_CELLS = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // [1:0] action
    input  logic [gmnq_pkg::S_TUSER_W-1:0]      s_axis_tuser,
    // [11:0] cell_req, [12] blocked_bit, [24:13] end_cell, [31:25] zero
    input  logic [gmnq_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [11:0] next_cell, [12] found, [16:13] degree, [17] rect_free, [23:18] zero
    output logic [gmnq_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                                m_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gmnq_pkg::APB_AW-1:0]         paddr,
    input  logic [gmnq_pkg::APB_DW-1:0]         pwdata,
    output logic [gmnq_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);

    localparam int CELL_W = gmnq_pkg::CELL_W;
    localparam int DIM_W  = gmnq_pkg::DIM_W;
    localparam int CALC_W = gmnq_pkg::CALC_W;
    localparam int PROD_W = gmnq_pkg::PROD_W;
    localparam int CNT_W  = gmnq_pkg::CNT_W;
    localparam int NDIR   = gmnq_pkg::NUM_DIR;
    localparam int APB_DW = gmnq_pkg::APB_DW;
    localparam int AW     = $clog2(MAX_CELLS);
    localparam int SZW    = $clog2(MAX_CELLS + 1);
    localparam int CMP_W  = ((SZW > CALC_W) ? SZW : CALC_W) + 1;
    localparam logic [AW-1:0]     CLR_LAST = AW'(MAX_CELLS - 1);
    localparam logic [PROD_W-1:0] SIZE_CAP = PROD_W'(MAX_CELLS);
    localparam logic [CNT_W-1:0]  DIV_LAST = CNT_W'(CELL_W - 1);

    typedef enum logic [8:0] {
        S_CLR    = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_WR     = 9'b000000100,
        S_DIV    = 9'b000001000,
        S_RMUL   = 9'b000010000,
        S_RSCAN  = 9'b000100000,
        S_RDRAIN = 9'b001000000,
        S_NREAD  = 9'b010000000,
        S_EMIT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Item registers.
    gmnq_pkg::action_t act_reg, act_next;
    logic [CELL_W-1:0] loc_reg, loc_next;
    logic [CELL_W-1:0] end_reg, end_next;
    logic              blk_reg, blk_next;

    // Configuration and derived map size.
    logic [DIM_W-1:0]  rows_reg, cols_reg;
    logic [PROD_W-1:0] cells_prod;
    logic [SZW-1:0]    size_reg;
    logic [CMP_W-1:0]  size_ext;

    // Divider.
    logic [DIM_W-1:0]  div_rem_reg, div_rem_next;
    logic [CELL_W-1:0] div_quo_reg, div_quo_next;
    logic [CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic              div_pass_reg, div_pass_next;
    logic [DIM_W:0]    div_trial;
    logic [DIM_W:0]    div_diff;
    logic              div_ge;
    logic [DIM_W-1:0]  rem_step;
    logic [CELL_W-1:0] quo_step;

    logic [CELL_W-1:0] row0_reg, row0_next;
    logic [CELL_W-1:0] col_reg, col_next;

    // Rectangle scan.
    logic [CELL_W-1:0] x_reg, x_next;
    logic [CELL_W-1:0] x1_reg, x1_next;
    logic [CELL_W-1:0] y_reg, y_next;
    logic [CELL_W-1:0] y0_reg, y0_next;
    logic [CELL_W-1:0] y1_reg, y1_next;
    logic [CALC_W-1:0] row_start_reg, row_start_next;
    logic [CALC_W-1:0] cell_reg, cell_next;
    logic [CALC_W-1:0] row_advance;
    logic              chk_reg, chk_next;
    logic              rfree_reg, rfree_next;
    logic              cell_on_map;
    logic [AW-1:0]     cell_addr;

    // Neighbor reads.
    logic [2:0]        nr_cnt_reg, nr_cnt_next;
    logic [NDIR-1:0]   free_reg, free_next;
    logic [NDIR-1:0]   sent_reg, sent_next;
    logic [CALC_W-1:0] cand [NDIR];
    logic [AW-1:0]     cand_addr [NDIR];
    logic [NDIR-1:0]   inmap;
    logic [NDIR-1:0]   geo;
    logic [NDIR-1:0]   rem_mask;
    logic [NDIR-1:0]   sel_oh;
    logic [2:0]        sel_idx;
    logic              sel_hit;
    logic              east_in_row;
    logic              west_in_row;
    logic [2:0]        deg_cnt;
    logic signed [gmnq_pkg::DEG_W-1:0] deg_val;

    // Clearing pass.
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    // Memory ports.
    logic            mem [MAX_CELLS];
    logic            mem_q;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic            wr_data;
    logic [AW-1:0]   rd_addr;
    logic [CMP_W-1:0] loc_ext;

    // Output register.
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [CELL_W-1:0]     m_next_reg, m_next_next;
    logic                  m_found_reg, m_found_next;
    logic signed [gmnq_pkg::DEG_W-1:0] m_deg_reg, m_deg_next;
    logic                  m_rfree_reg, m_rfree_next;
    logic                  m_last_reg, m_last_next;
    logic                  out_free;
    logic                  s_acc;
    logic                  cfg_wr;

    // ------------------------------------------------------------------
    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == gmnq_pkg::REG_COLS) ? APB_DW'(cols_reg) : APB_DW'(rows_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= DIM_W'(64);
            cols_reg <= DIM_W'(64);
        end else if (cfg_wr) begin
            if (paddr[2] == gmnq_pkg::REG_COLS) begin
                cols_reg <= pwdata[DIM_W-1:0];
            end else begin
                rows_reg <= pwdata[DIM_W-1:0];
            end
        end
    end

    assign cells_prod = PROD_W'(rows_reg) * PROD_W'(cols_reg);

    always_ff @(posedge aclk) begin
        size_reg <= (cells_prod > SIZE_CAP) ? SZW'(SIZE_CAP) : SZW'(cells_prod);
    end

    assign size_ext = CMP_W'(size_reg);

    // ------------------------------------------------------------------
    // Obstacle memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        mem_q <= mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Divider step: restoring, one quotient bit per cycle.
    assign div_trial = {div_rem_reg, div_quo_reg[CELL_W-1]};
    assign div_ge    = div_trial >= {1'b0, cols_reg};
    assign div_diff  = div_trial - {1'b0, cols_reg};
    assign rem_step  = div_ge ? div_diff[DIM_W-1:0] : div_trial[DIM_W-1:0];
    assign quo_step  = {div_quo_reg[CELL_W-2:0], div_ge};

    // ------------------------------------------------------------------
    // The five candidate cells of a query, in the order wait, north, east,
    // south, west. Only on-map candidates are read back as free.
    always_comb begin
        cand[gmnq_pkg::DIR_WAIT]  = CALC_W'(loc_reg);
        cand[gmnq_pkg::DIR_NORTH] = CALC_W'(loc_reg) - CALC_W'(cols_reg);
        cand[gmnq_pkg::DIR_EAST]  = CALC_W'(loc_reg) + CALC_W'(1);
        cand[gmnq_pkg::DIR_SOUTH] = CALC_W'(loc_reg) + CALC_W'(cols_reg);
        cand[gmnq_pkg::DIR_WEST]  = CALC_W'(loc_reg) - CALC_W'(1);
        for (int i = 0; i < NDIR; i++) begin
            inmap[i]     = CMP_W'(cand[i]) < size_ext;
            cand_addr[i] = AW'(CMP_W'(cand[i]));
        end
        // North and west must not step below cell zero.
        inmap[gmnq_pkg::DIR_NORTH] = inmap[gmnq_pkg::DIR_NORTH] &&
                                     (DIM_W'(loc_reg) >= cols_reg);
        inmap[gmnq_pkg::DIR_WEST]  = inmap[gmnq_pkg::DIR_WEST] && (loc_reg != '0);
    end

    assign east_in_row = (DIM_W'(col_reg) + DIM_W'(1)) < cols_reg;
    assign west_in_row = col_reg != '0;

    // A one-column grid lets east and west step onto the next or previous row.
    always_comb begin
        geo = '1;
        geo[gmnq_pkg::DIR_EAST] = east_in_row || (cols_reg == DIM_W'(1));
        geo[gmnq_pkg::DIR_WEST] = west_in_row || (cols_reg == DIM_W'(1));
    end

    assign rem_mask = free_reg & geo & ~sent_reg;

    always_comb begin
        sel_idx = '0;
        sel_hit = 1'b0;
        for (int i = 0; i < NDIR; i++) begin
            if (rem_mask[i] && !sel_hit) begin
                sel_idx = 3'(i);
                sel_hit = 1'b1;
            end
        end
        sel_oh = NDIR'(1) << sel_idx;
    end

    assign deg_cnt = 3'(free_reg[gmnq_pkg::DIR_NORTH])
                   + 3'(free_reg[gmnq_pkg::DIR_SOUTH])
                   + 3'(free_reg[gmnq_pkg::DIR_WEST] && west_in_row)
                   + 3'(free_reg[gmnq_pkg::DIR_EAST] && east_in_row);
    assign deg_val = free_reg[gmnq_pkg::DIR_WAIT] ? $signed({1'b0, deg_cnt})
                                                  : gmnq_pkg::DEG_NONE;

    assign cell_on_map = CMP_W'(cell_reg) < size_ext;
    assign cell_addr   = AW'(CMP_W'(cell_reg));
    assign row_advance = row_start_reg + CALC_W'(cols_reg);
    assign loc_ext     = CMP_W'(loc_reg);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_tvalid_reg || m_axis_tready;

    // ------------------------------------------------------------------
    // Sequencer. Memory writes happen only in the clearing pass and in the
    // write state, and reads only in later states, so a read never meets a
    // write to the same cell in flight.
    always_comb begin
        state_next     = state_reg;
        act_next       = act_reg;
        loc_next       = loc_reg;
        end_next       = end_reg;
        blk_next       = blk_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        div_cnt_next   = div_cnt_reg;
        div_pass_next  = div_pass_reg;
        row0_next      = row0_reg;
        col_next       = col_reg;
        x_next         = x_reg;
        x1_next        = x1_reg;
        y_next         = y_reg;
        y0_next        = y0_reg;
        y1_next        = y1_reg;
        row_start_next = row_start_reg;
        cell_next      = cell_reg;
        chk_next       = chk_reg;
        rfree_next     = rfree_reg;
        nr_cnt_next    = nr_cnt_reg;
        free_next      = free_reg;
        sent_next      = sent_reg;
        clr_cnt_next   = clr_cnt_reg;
        wr_en          = 1'b0;
        wr_addr        = clr_cnt_reg;
        wr_data        = 1'b0;
        rd_addr        = cell_addr;
        m_tvalid_next  = m_tvalid_reg && !m_axis_tready;
        m_next_next    = m_next_reg;
        m_found_next   = m_found_reg;
        m_deg_next     = m_deg_reg;
        m_rfree_next   = m_rfree_reg;
        m_last_next    = m_last_reg;

        case (state_reg)
            S_CLR: begin
                wr_en        = 1'b1;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    act_next      = gmnq_pkg::action_t'(s_axis_tuser);
                    loc_next      = s_axis_tdata[gmnq_pkg::S_CELL_LSB +: CELL_W];
                    blk_next      = s_axis_tdata[gmnq_pkg::S_BLOCKED_BIT];
                    end_next      = s_axis_tdata[gmnq_pkg::S_END_LSB +: CELL_W];
                    div_rem_next  = '0;
                    div_quo_next  = s_axis_tdata[gmnq_pkg::S_CELL_LSB +: CELL_W];
                    div_cnt_next  = '0;
                    div_pass_next = 1'b0;
                    if (gmnq_pkg::action_t'(s_axis_tuser) == gmnq_pkg::ACT_WRITE) begin
                        state_next = S_WR;
                    end else begin
                        state_next = S_DIV;
                    end
                end
            end
            S_WR: begin
                wr_en      = loc_ext < size_ext;
                wr_addr    = AW'(loc_ext);
                wr_data    = blk_reg;
                state_next = S_IDLE;
            end
            S_DIV: begin
                div_rem_next = rem_step;
                div_quo_next = quo_step;
                div_cnt_next = div_cnt_reg + CNT_W'(1);
                if (div_cnt_reg == DIV_LAST) begin
                    if (!div_pass_reg) begin
                        row0_next = quo_step;
                        col_next  = rem_step[CELL_W-1:0];
                        if (act_reg == gmnq_pkg::ACT_RECT) begin
                            if (cols_reg == '0) begin
                                // Empty grid: nothing can be blocked.
                                rfree_next = 1'b1;
                                state_next = S_EMIT;
                            end else begin
                                div_rem_next  = '0;
                                div_quo_next  = end_reg;
                                div_cnt_next  = '0;
                                div_pass_next = 1'b1;
                            end
                        end else begin
                            nr_cnt_next = '0;
                            sent_next   = '0;
                            state_next  = S_NREAD;
                        end
                    end else begin
                        x_next  = (row0_reg < quo_step) ? row0_reg : quo_step;
                        x1_next = (row0_reg < quo_step) ? quo_step : row0_reg;
                        if (col_reg < rem_step[CELL_W-1:0]) begin
                            y0_next = col_reg;
                            y1_next = rem_step[CELL_W-1:0];
                        end else begin
                            y0_next = rem_step[CELL_W-1:0];
                            y1_next = col_reg;
                        end
                        state_next = S_RMUL;
                    end
                end
            end
            S_RMUL: begin
                row_start_next = CALC_W'(x_reg * cols_reg) + CALC_W'(y0_reg);
                cell_next      = CALC_W'(x_reg * cols_reg) + CALC_W'(y0_reg);
                y_next         = y0_reg;
                chk_next       = 1'b0;
                rfree_next     = 1'b1;
                state_next     = S_RSCAN;
            end
            S_RSCAN: begin
                // Issue the read of this cell and judge the one read last cycle.
                rd_addr  = cell_addr;
                chk_next = cell_on_map;
                if (chk_reg && mem_q) begin
                    rfree_next = 1'b0;
                    state_next = S_EMIT;
                end else if (x_reg == x1_reg && y_reg == y1_reg) begin
                    state_next = S_RDRAIN;
                end else if (y_reg == y1_reg) begin
                    x_next         = x_reg + CELL_W'(1);
                    y_next         = y0_reg;
                    row_start_next = row_advance;
                    cell_next      = row_advance;
                end else begin
                    y_next    = y_reg + CELL_W'(1);
                    cell_next = cell_reg + CALC_W'(1);
                end
            end
            S_RDRAIN: begin
                if (chk_reg && mem_q) begin
                    rfree_next = 1'b0;
                end
                state_next = S_EMIT;
            end
            S_NREAD: begin
                if (nr_cnt_reg < 3'(NDIR)) begin
                    rd_addr = cand_addr[nr_cnt_reg];
                end
                for (int i = 0; i < NDIR; i++) begin
                    if (nr_cnt_reg == 3'(i + 1)) begin
                        free_next[i] = inmap[i] && !mem_q;
                    end
                end
                nr_cnt_next = nr_cnt_reg + 3'd1;
                if (nr_cnt_reg == 3'(NDIR)) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_next_next   = '0;
                    m_found_next  = 1'b0;
                    m_deg_next    = '0;
                    m_rfree_next  = 1'b0;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                    case (act_reg)
                        gmnq_pkg::ACT_MOVES: begin
                            if (sel_hit) begin
                                m_next_next  = cand[sel_idx][CELL_W-1:0];
                                m_found_next = 1'b1;
                                m_last_next  = (rem_mask & ~sel_oh) == '0;
                                sent_next    = sent_reg | sel_oh;
                                if ((rem_mask & ~sel_oh) != '0) begin
                                    state_next = S_EMIT;
                                end
                            end
                        end
                        gmnq_pkg::ACT_DEGREE: begin
                            m_deg_next = deg_val;
                        end
                        gmnq_pkg::ACT_RECT: begin
                            m_rfree_next = rfree_reg;
                        end
                        default: begin
                            m_tvalid_next = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg       <= act_next;
        loc_reg       <= loc_next;
        end_reg       <= end_next;
        blk_reg       <= blk_next;
        div_rem_reg   <= div_rem_next;
        div_quo_reg   <= div_quo_next;
        div_cnt_reg   <= div_cnt_next;
        div_pass_reg  <= div_pass_next;
        row0_reg      <= row0_next;
        col_reg       <= col_next;
        x_reg         <= x_next;
        x1_reg        <= x1_next;
        y_reg         <= y_next;
        y0_reg        <= y0_next;
        y1_reg        <= y1_next;
        row_start_reg <= row_start_next;
        cell_reg      <= cell_next;
        chk_reg       <= chk_next;
        rfree_reg     <= rfree_next;
        nr_cnt_reg    <= nr_cnt_next;
        free_reg      <= free_next;
        sent_reg      <= sent_next;
        m_next_reg    <= m_next_next;
        m_found_reg   <= m_found_next;
        m_deg_reg     <= m_deg_next;
        m_rfree_reg   <= m_rfree_next;
        m_last_reg    <= m_last_next;
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {{gmnq_pkg::M_PAD_W{1'b0}}, m_rfree_reg, m_deg_reg,
                            m_found_reg, m_next_reg};

endmodule

// File: rtl/core/gmnq_checker.sv
// Port-level checks of the grid map neighbor query block, bound to its top level.
// Depends on gmnq_pkg and grid_map_neighbor_query_core.
module gmnq_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [gmnq_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tlast,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready
);

    logic [gmnq_pkg::CELL_W-1:0] out_next;
    logic                        out_found;
    logic [gmnq_pkg::DEG_W-1:0]  out_deg;

    assign out_next  = m_axis_tdata[gmnq_pkg::M_NEXT_LSB +: gmnq_pkg::CELL_W];
    assign out_found = m_axis_tdata[gmnq_pkg::M_FOUND_BIT];
    assign out_deg   = m_axis_tdata[gmnq_pkg::M_DEG_LSB +: gmnq_pkg::DEG_W];

    // The map is being cleared right after reset, so no item may enter.
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_axis_tready)
        else $error("input ready during the clearing pass");

    // One item at a time: ready drops once an item is taken.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item accepted while one is in work");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

    // A result without a legal move carries no destination cell.
    a_no_move_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !out_found) |-> (out_next == '0))
        else $error("destination cell set without a legal move");

    a_degree_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ((out_deg == gmnq_pkg::DEG_NONE) ||
                           (out_deg <= gmnq_pkg::DEG_MAX)))
        else $error("degree out of range");

endmodule

bind grid_map_neighbor_query_core gmnq_checker u_gmnq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

// File: tb/testbench.sv
// Self-checking testbench for grid_map_neighbor_query_core: obstacle writes, move lists,
// degree counts and rectangle checks under random stalls and several grid shapes.
// Depends on gmnq_pkg and the core RTL only.
`timescale 1ns / 1ps

localparam int MAP_DEPTH = 4096;

typedef struct {
    logic [gmnq_pkg::CELL_W-1:0]       next_cell;
    logic                              found;
    logic signed [gmnq_pkg::DEG_W-1:0] degree;
    logic                              rect_free;
    logic                              last;
} grid_result_t;

class neighbor_scoreboard;
    bit           blocked_cells [MAP_DEPTH];
    int           grid_rows = 64;
    int           grid_cols = 64;
    grid_result_t pending_results [$];
    int           failures = 0;

    function void set_dim(logic idx, logic [gmnq_pkg::DIM_W-1:0] value);
        if (idx == gmnq_pkg::REG_ROWS) begin
            grid_rows = value;
        end else begin
            grid_cols = value;
        end
    endfunction

    function int grid_size();
        int prod;
        prod = grid_rows * grid_cols;
        return (prod > MAP_DEPTH) ? MAP_DEPTH : prod;
    endfunction

    function void add_result(int nc, logic fd, logic signed [gmnq_pkg::DEG_W-1:0] deg,
                             logic rf, logic last);
        grid_result_t r;
        r.next_cell = nc[gmnq_pkg::CELL_W-1:0];
        r.found     = fd;
        r.degree    = deg;
        r.rect_free = rf;
        r.last      = last;
        pending_results = {pending_results, r};
    endfunction

    // A move counts when it lands on the map at Manhattan distance below two, so a
    // step that wraps across a row is rejected.
    function bit move_legal(int curr, int next, int size);
        int dx, dy;
        if (grid_cols == 0 || next < 0 || next >= size) return 1'b0;
        dx = next / grid_cols - curr / grid_cols;
        dy = next % grid_cols - curr % grid_cols;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return (dx + dy) < 2;
    endfunction

    function void note_request(gmnq_pkg::action_t act, logic [gmnq_pkg::CELL_W-1:0] req_cell,
                               logic blk, logic [gmnq_pkg::CELL_W-1:0] endc);
        int size, loc, far, nx, n, k, deg, dir;
        int offs [gmnq_pkg::NUM_DIR];
        int dest [gmnq_pkg::NUM_DIR];
        int x, y, x0, x1, y0, y1, c;
        logic clear;
        size = grid_size();
        loc  = req_cell;
        far  = endc;
        case (act)
            gmnq_pkg::ACT_WRITE: begin
                if (loc < size) blocked_cells[loc] = blk;
            end
            gmnq_pkg::ACT_MOVES: begin
                offs[gmnq_pkg::DIR_WAIT]  = 0;
                offs[gmnq_pkg::DIR_NORTH] = -grid_cols;
                offs[gmnq_pkg::DIR_EAST]  = 1;
                offs[gmnq_pkg::DIR_SOUTH] = grid_cols;
                offs[gmnq_pkg::DIR_WEST]  = -1;
                n = 0;
                for (dir = gmnq_pkg::DIR_WAIT; dir <= gmnq_pkg::DIR_WEST; dir++) begin
                    nx = loc + offs[dir];
                    if (move_legal(loc, nx, size) && !blocked_cells[nx]) begin
                        dest[n] = nx;
                        n++;
                    end
                end
                if (n == 0) begin
                    add_result(0, 1'b0, '0, 1'b0, 1'b1);
                end
                for (k = 0; k < n; k++) begin
                    add_result(dest[k], 1'b1, '0, 1'b0, k == n - 1);
                end
            end
            gmnq_pkg::ACT_DEGREE: begin
                if (grid_cols == 0 || loc >= size || blocked_cells[loc]) begin
                    deg = gmnq_pkg::DEG_NONE;
                end else begin
                    deg = 0;
                    if (loc >= grid_cols && !blocked_cells[loc - grid_cols]) deg++;
                    if (loc + grid_cols < size && !blocked_cells[loc + grid_cols]) deg++;
                    if (loc % grid_cols > 0 && !blocked_cells[loc - 1]) deg++;
                    if (loc % grid_cols < grid_cols - 1 && loc + 1 < size &&
                        !blocked_cells[loc + 1]) deg++;
                end
                add_result(0, 1'b0, deg[gmnq_pkg::DEG_W-1:0], 1'b0, 1'b1);
            end
            default: begin
                // Cells past the end of the map are treated as free.
                clear = 1'b1;
                if (grid_cols != 0) begin
                    x0 = loc / grid_cols;
                    x1 = far / grid_cols;
                    y0 = loc % grid_cols;
                    y1 = far % grid_cols;
                    if (x0 > x1) begin
                        c = x0; x0 = x1; x1 = c;
                    end
                    if (y0 > y1) begin
                        c = y0; y0 = y1; y1 = c;
                    end
                    for (x = x0; x <= x1 && clear; x++) begin
                        for (y = y0; y <= y1 && clear; y++) begin
                            c = x * grid_cols + y;
                            if (c < size && blocked_cells[c]) clear = 1'b0;
                        end
                    end
                end
                add_result(0, 1'b0, '0, clear, 1'b1);
            end
        endcase
    endfunction

    function string show(grid_result_t r);
        return $sformatf("next=%0d found=%0d degree=%0d rect_free=%0d last=%0d",
                         r.next_cell, r.found, r.degree, r.rect_free, r.last);
    endfunction

    function void check_result(logic [gmnq_pkg::M_TDATA_W-1:0] word, logic tlast);
        grid_result_t got, want;
        got.next_cell = word[gmnq_pkg::M_NEXT_LSB +: gmnq_pkg::CELL_W];
        got.found     = word[gmnq_pkg::M_FOUND_BIT];
        got.degree    = word[gmnq_pkg::M_DEG_LSB +: gmnq_pkg::DEG_W];
        got.rect_free = word[gmnq_pkg::M_RFREE_BIT];
        got.last      = tlast;
        if (pending_results.size() == 0) begin
            failures++;
            if (failures <= 10) $display("unexpected result: %s", show(got));
        end else begin
            want = pending_results.pop_front();
            if (got.next_cell !== want.next_cell || got.found !== want.found ||
                got.degree !== want.degree || got.rect_free !== want.rect_free ||
                got.last !== want.last) begin
                failures++;
                if (failures <= 10) begin
                    $display("result mismatch: expected %s, got %s", show(want), show(got));
                end
            end
        end
    endfunction
endclass

module testbench;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int DRAIN_CYCLES   = 20;
    localparam int NUM_PHASES     = 12;
    localparam int PHASE_ITEMS    = 27;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic [gmnq_pkg::S_TUSER_W-1:0]      s_axis_tuser = '0;
    logic [gmnq_pkg::S_TDATA_W-1:0]      s_axis_tdata = '0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [gmnq_pkg::M_TDATA_W-1:0]      m_axis_tdata;
    logic                                m_axis_tlast;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [gmnq_pkg::APB_AW-1:0]         paddr = '0;
    logic [gmnq_pkg::APB_DW-1:0]         pwdata = '0;
    logic [gmnq_pkg::APB_DW-1:0]         prdata;
    logic                                pready;

    logic gaps_on = 1'b1;
    int   quiet_cycles = 0;
    int   phase_rows [NUM_PHASES] = '{64, 1, 4096, 1, 0, 64, 8191, 5, 3, 37, 4096, 2};
    int   phase_cols [NUM_PHASES] = '{64, 4096, 1, 1, 64, 0, 8191, 7, 3, 11, 4096, 2};

    neighbor_scoreboard board = new();

    grid_map_neighbor_query_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (gaps_on) begin
            m_axis_tready <= ($urandom_range(99) >= 17);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            board.check_result(m_axis_tdata, m_axis_tlast);
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Valid is only lowered when a gap starts, so back-to-back items keep it high.
    task automatic send_item(input gmnq_pkg::action_t act, input int req_cell, input logic blk,
                             input int endc);
        logic [gmnq_pkg::CELL_W-1:0]    c12, e12;
        logic [gmnq_pkg::S_TDATA_W-1:0] word;
        c12 = req_cell[gmnq_pkg::CELL_W-1:0];
        e12 = endc[gmnq_pkg::CELL_W-1:0];
        word = '0;
        word[gmnq_pkg::S_CELL_LSB +: gmnq_pkg::CELL_W] = c12;
        word[gmnq_pkg::S_BLOCKED_BIT]                  = blk;
        word[gmnq_pkg::S_END_LSB +: gmnq_pkg::CELL_W]  = e12;
        if (gaps_on) begin
            while ($urandom_range(99) < 17) begin
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_axis_tuser  <= act;
        s_axis_tdata  <= word;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        board.note_request(act, c12, blk, e12);
    endtask

    task automatic apb_write(input logic idx, input logic [gmnq_pkg::DIM_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= gmnq_pkg::APB_DW'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        board.set_dim(idx, value);
    endtask

    task automatic set_grid(input logic [gmnq_pkg::DIM_W-1:0] rows,
                            input logic [gmnq_pkg::DIM_W-1:0] cols);
        apb_write(gmnq_pkg::REG_ROWS, rows);
        apb_write(gmnq_pkg::REG_COLS, cols);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes cause no result, so a settling wait after the last result covers one still in flight.
    task automatic wait_drained();
        while (board.pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic int near_offset();
        case ($urandom_range(gmnq_pkg::NUM_DIR - 1))
            gmnq_pkg::DIR_NORTH: return -board.grid_cols;
            gmnq_pkg::DIR_EAST:  return 1;
            gmnq_pkg::DIR_SOUTH: return board.grid_cols;
            gmnq_pkg::DIR_WEST:  return -1;
            default:             return 0;
        endcase
    endfunction

    // Mostly local clusters: obstacles dropped around a cell, then a query on it.
    // The rest is noise over the whole field range.
    task automatic run_random(input int target);
        int                done, size, center, spot, k, writes, corner;
        gmnq_pkg::action_t act;
        done = 0;
        while (done < target) begin
            size = board.grid_size();
            if ($urandom_range(99) < 70) begin
                center = (size > 0) ? $urandom_range(size - 1) : $urandom_range(MAP_DEPTH - 1);
                writes = $urandom_range(3);
                for (k = 0; k < writes; k++) begin
                    spot = (center + near_offset()) & (MAP_DEPTH - 1);
                    send_item(gmnq_pkg::ACT_WRITE, spot, $urandom_range(99) < 40,
                              $urandom_range(MAP_DEPTH - 1));
                    if (spot < size) done++;
                end
                act    = gmnq_pkg::action_t'($urandom_range(gmnq_pkg::ACT_MOVES,
                                                            gmnq_pkg::ACT_RECT));
                corner = center + $urandom_range(3) * board.grid_cols + $urandom_range(3);
                send_item(act, center, $urandom_range(1), corner);
                done++;
            end else begin
                act  = gmnq_pkg::action_t'($urandom_range(gmnq_pkg::ACT_RECT));
                spot = $urandom_range(MAP_DEPTH - 1);
                send_item(act, spot, $urandom_range(1), $urandom_range(MAP_DEPTH - 1));
                if (act != gmnq_pkg::ACT_WRITE || spot < size) done++;
            end
        end
    endtask

    initial begin
        int ph;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed items on the 64 x 64 reset grid.
        send_item(gmnq_pkg::ACT_MOVES, 0, 1'b0, 0);          // top-left corner
        send_item(gmnq_pkg::ACT_MOVES, 4095, 1'b0, 0);       // bottom-right corner
        send_item(gmnq_pkg::ACT_DEGREE, 0, 1'b0, 0);
        send_item(gmnq_pkg::ACT_RECT, 0, 1'b0, 4095);        // whole map, all free
        send_item(gmnq_pkg::ACT_WRITE, 65, 1'b1, 0);
        send_item(gmnq_pkg::ACT_MOVES, 64, 1'b0, 0);         // west would wrap a row
        send_item(gmnq_pkg::ACT_DEGREE, 65, 1'b0, 0);        // blocked cell
        send_item(gmnq_pkg::ACT_DEGREE, 66, 1'b0, 0);
        send_item(gmnq_pkg::ACT_RECT, 0, 1'b0, 130);
        send_item(gmnq_pkg::ACT_RECT, 4095, 1'b0, 0);        // corners given in reverse
        send_item(gmnq_pkg::ACT_WRITE, 0, 1'b1, 0);
        send_item(gmnq_pkg::ACT_WRITE, 1, 1'b1, 0);
        send_item(gmnq_pkg::ACT_WRITE, 64, 1'b1, 0);
        send_item(gmnq_pkg::ACT_MOVES, 0, 1'b0, 0);          // boxed in: no legal move
        send_item(gmnq_pkg::ACT_WRITE, 0, 1'b0, 0);
        send_item(gmnq_pkg::ACT_DEGREE, 0, 1'b0, 0);
        send_item(gmnq_pkg::ACT_WRITE, 4095, 1'b1, 4095);
        send_item(gmnq_pkg::ACT_DEGREE, 4095, 1'b1, 4095);
        send_item(gmnq_pkg::ACT_MOVES, 4094, 1'b0, 0);
        send_item(gmnq_pkg::ACT_RECT, 4032, 1'b0, 4095);     // bottom row
        s_axis_tvalid <= 1'b0;
        wait_drained();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            gaps_on = !(ph == 2 || ph == 3);
            set_grid(phase_rows[ph], phase_cols[ph]);
            run_random(PHASE_ITEMS);
            s_axis_tvalid <= 1'b0;
            wait_drained();
        end
        gaps_on = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.failures == 0 && board.pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// File: grid_map_neighbor_query_core.f
rtl/core/gmnq_pkg.sv
rtl/core/grid_map_neighbor_query_core.sv
rtl/core/gmnq_checker.sv
tb/testbench.sv
